@@ rtl/core/mpc_pkg.sv @@
// shared types and constants for the magic packet checker
package mpc_pkg;

  localparam int unsigned MacBytes = 6;
  localparam int unsigned MacW     = 8 * MacBytes;
  localparam logic [7:0]  FillByte = 8'hff;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StMismatch = 3'd2,
    StRepeat   = 3'd3,
    StFamily   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CfgFilterEn = 2'd0,
    CfgExpMac   = 2'd1,
    CfgFwdV4    = 2'd2,
    CfgFwdV6    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindPrefix  = 2'd1,
    KindCapture = 2'd2,
    KindCompare = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       is_ipv6;
  } in_item_t;

  typedef struct packed {
    logic            forward;
    logic [2:0]      status;
    logic [MacW-1:0] wake_mac;
    logic            family_ipv6;
  } out_item_t;

  // classified byte handed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [2:0] mac_idx;
    logic       restart;
    logic       last;
    logic       too_short;
    logic       is_ipv6;
  } op_t;

  typedef struct packed {
    logic            filter_en;
    logic [MacW-1:0] exp_mac;
    logic            fwd_v4;
    logic            fwd_v6;
  } cfg_t;

endpackage

@@ rtl/core/mpc_front.sv @@
// front end: tracks byte position and classifies each payload byte
module mpc_front import mpc_pkg::*; #(
  parameter int unsigned PREFIX_LEN   = 6,
  parameter int unsigned REPEAT_COUNT = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  input  logic     full_i,
  output op_t      op_o
);

  localparam int unsigned FullLen = PREFIX_LEN + MacBytes * REPEAT_COUNT;
  localparam int unsigned PosW    = $clog2(FullLen + 1);

  logic [PosW-1:0] pos_q, pos_d, pos_cur, pos_nxt;
  logic [2:0]      idx_q, idx_d, idx_cur, idx_nxt;
  logic            restart, accept;
  kind_e           kind;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    restart = in_data_i.first_byte || (pos_q == '0);
    pos_cur = restart ? '0 : pos_q;
    idx_cur = restart ? '0 : idx_q;
    if (pos_cur < PosW'(FullLen)) begin
      pos_nxt = pos_cur + PosW'(1);
      if (pos_cur < PosW'(PREFIX_LEN)) begin
        kind = KindPrefix;
      end else if (pos_cur < PosW'(PREFIX_LEN + MacBytes)) begin
        kind = KindCapture;
      end else begin
        kind = KindCompare;
      end
    end else begin
      pos_nxt = pos_cur;
      kind    = KindNone;
    end
    // byte index within one mac copy
    if (kind == KindCapture || kind == KindCompare) begin
      idx_nxt = (idx_cur == 3'(MacBytes - 1)) ? '0 : idx_cur + 3'd1;
    end else begin
      idx_nxt = '0;
    end
  end

  always_comb begin
    op_o.kind      = kind;
    op_o.data      = in_data_i.data_byte;
    op_o.mac_idx   = idx_cur;
    op_o.restart   = restart;
    op_o.last      = in_data_i.last_byte;
    op_o.too_short = pos_nxt < PosW'(FullLen);
    op_o.is_ipv6   = in_data_i.is_ipv6;
  end

  always_comb begin
    pos_d = pos_q;
    idx_d = idx_q;
    if (accept) begin
      if (in_data_i.last_byte) begin
        pos_d = '0;
        idx_d = '0;
      end else begin
        pos_d = pos_nxt;
        idx_d = idx_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      idx_q <= '0;
    end else begin
      pos_q <= pos_d;
      idx_q <= idx_d;
    end
  end

endmodule

@@ rtl/core/mpc_fifo.sv @@
// two-entry queue between front and back
module mpc_fifo import mpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  head_o
);

  op_t        mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/core/mpc_back.sv @@
// back end: prefix check, mac capture, repeat compare and the verdict register
module mpc_back import mpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  op_t       head_i,
  output logic      pop_o,
  input  cfg_t      cfg_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [MacW-1:0] mac_q, mac_d, mac_cur;
  logic            pgood_q, pgood_d, pgood_cur;
  logic            rgood_q, rgood_d, rgood_cur;
  logic            fam_q, fam_d, fam_cur;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d, verdict;
  logic            out_free;
  logic [7:0]      ref_byte;
  logic            fam_en;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = !empty_i && (!head_i.last || out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mac_cur   = head_i.restart ? '0 : mac_q;
    pgood_cur = head_i.restart ? 1'b1 : pgood_q;
    rgood_cur = head_i.restart ? 1'b1 : rgood_q;
    fam_cur   = head_i.restart ? head_i.is_ipv6 : fam_q;

    case (head_i.mac_idx)
      3'd0:    ref_byte = mac_cur[47:40];
      3'd1:    ref_byte = mac_cur[39:32];
      3'd2:    ref_byte = mac_cur[31:24];
      3'd3:    ref_byte = mac_cur[23:16];
      3'd4:    ref_byte = mac_cur[15:8];
      default: ref_byte = mac_cur[7:0];
    endcase

    case (head_i.kind)
      KindPrefix: begin
        if (head_i.data != FillByte) pgood_cur = 1'b0;
      end
      KindCapture: begin
        mac_cur = {mac_cur[MacW-9:0], head_i.data};
      end
      KindCompare: begin
        if (head_i.data != ref_byte) rgood_cur = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    fam_en              = fam_cur ? cfg_i.fwd_v6 : cfg_i.fwd_v4;
    verdict.forward     = 1'b0;
    verdict.wake_mac    = mac_cur;
    verdict.family_ipv6 = fam_cur;
    if (head_i.too_short) begin
      verdict.status   = StShort;
      verdict.wake_mac = '0;
    end else if (cfg_i.filter_en) begin
      verdict.status = (pgood_cur && rgood_cur && mac_cur == cfg_i.exp_mac) ? StOk
                                                                            : StMismatch;
    end else if (!pgood_cur) begin
      verdict.status = StMismatch;
    end else if (!rgood_cur) begin
      verdict.status = StRepeat;
    end else begin
      verdict.status = StOk;
    end
    if (verdict.status == StOk) begin
      if (fam_en) begin
        verdict.forward = 1'b1;
      end else begin
        verdict.status = StFamily;
      end
    end
  end

  always_comb begin
    mac_d       = mac_q;
    pgood_d     = pgood_q;
    rgood_d     = rgood_q;
    fam_d       = fam_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      fam_d = fam_cur;
      if (head_i.last) begin
        // verdict given, checking restarts
        mac_d       = '0;
        pgood_d     = 1'b1;
        rgood_d     = 1'b1;
        out_d       = verdict;
        out_valid_d = 1'b1;
      end else begin
        mac_d   = mac_cur;
        pgood_d = pgood_cur;
        rgood_d = rgood_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q       <= '0;
      pgood_q     <= 1'b1;
      rgood_q     <= 1'b1;
      fam_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mac_q       <= mac_d;
      pgood_q     <= pgood_d;
      rgood_q     <= rgood_d;
      fam_q       <= fam_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/magic_packet_checker_core.sv @@
// top level of the wake-on-lan magic packet checker
// Takes one payload byte per clock cycle while in_stall_o is low. A verdict is formed once
// the last byte of a payload has passed through the two-entry queue between the classifier
// and the checker, which then loads the verdict into the output register behind out_valid_o.
// Throughput is set by the back-end checker, which retires one byte per cycle unless a last
// byte waits for the output register to free up; the queue and the output register let the
// input keep flowing while a verdict waits on out_stall_i, until the next payload's last byte
// reaches the checker.
// Configuration is taken through a write-only port and is sampled when a verdict
// is formed, so write it only while no payload is in flight.
module magic_packet_checker_core import mpc_pkg::*; #(
  parameter int unsigned PREFIX_LEN   = 6,
  parameter int unsigned REPEAT_COUNT = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [MacW-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  op_t  push_op, head_op;
  logic push, full, empty, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFilterEn: cfg_d.filter_en = cfg_data_i[0];
        CfgExpMac:   cfg_d.exp_mac   = cfg_data_i;
        CfgFwdV4:    cfg_d.fwd_v4    = cfg_data_i[0];
        CfgFwdV6:    cfg_d.fwd_v6    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mpc_front #(
    .PREFIX_LEN  (PREFIX_LEN),
    .REPEAT_COUNT(REPEAT_COUNT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .full_i    (full),
    .op_o      (push_op)
  );

  mpc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_op),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_op)
  );

  mpc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head_op),
    .pop_o      (pop),
    .cfg_i      (cfg_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ test/tb_magic_packet_checker_core.sv @@
// self-checking testbench for magic_packet_checker_core with a verdict predictor
module tb_magic_packet_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mpc_pkg::*;

  localparam int unsigned PrefixLen   = 6;
  localparam int unsigned RepeatCount = 16;
  localparam int unsigned FullLen     = PrefixLen + MacBytes * RepeatCount;
  localparam int unsigned CycleLimit  = 300_000;
  localparam int unsigned PrintLimit  = 200;

  typedef logic [7:0] byte_q_t[$];

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  in_item_t        in_item;
  logic            out_valid;
  logic            out_stall;
  out_item_t       out_item;
  logic            cfg_we;
  cfg_idx_e        cfg_idx;
  logic [MacW-1:0] cfg_data;

  always #5 clk = ~clk;

  magic_packet_checker_core #(
    .PREFIX_LEN  (PrefixLen),
    .REPEAT_COUNT(RepeatCount)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow of the checker state and its registers
  int unsigned     sh_pos;
  logic [MacW-1:0] sh_mac;
  bit              sh_prefix_ok;
  bit              sh_reps_ok;
  bit              sh_v6;
  cfg_t            sh_cfg;
  out_item_t       verdict_q[$];

  int unsigned err_cnt;
  int unsigned verdict_cnt;
  int unsigned fwd_cnt;
  int unsigned bytes_sent;
  int unsigned payload_cnt;
  int unsigned closed_cnt;
  int unsigned phase_cnt;

  bit   quiet;
  bit   in_gaps;
  bit   open_payload;
  cfg_t cur_cfg;

  task automatic clear_checks();
    sh_pos       = 0;
    sh_mac       = '0;
    sh_prefix_ok = 1'b1;
    sh_reps_ok   = 1'b1;
  endtask

  task automatic predict_verdict(input in_item_t it);
    out_item_t   v;
    status_e     st;
    int unsigned q;
    if (it.first_byte || sh_pos == 0) begin
      clear_checks();
      sh_v6 = it.is_ipv6;
    end
    if (sh_pos < FullLen) begin
      if (sh_pos < PrefixLen) begin
        if (it.data_byte != FillByte) sh_prefix_ok = 1'b0;
      end else begin
        q = sh_pos - PrefixLen;
        if (q < MacBytes) begin
          sh_mac = {sh_mac[MacW-9:0], it.data_byte};
        end else if (sh_mac[8*(MacBytes-1-q%MacBytes) +: 8] != it.data_byte) begin
          sh_reps_ok = 1'b0;
        end
      end
      sh_pos++;
    end
    if (it.last_byte) begin
      v = '0;
      v.family_ipv6 = sh_v6;
      if (sh_pos < FullLen) begin
        st = StShort;
      end else begin
        v.wake_mac = sh_mac;
        if (sh_cfg.filter_en) begin
          st = (sh_prefix_ok && sh_reps_ok && sh_mac == sh_cfg.exp_mac) ? StOk : StMismatch;
        end else if (!sh_prefix_ok) begin
          st = StMismatch;
        end else if (!sh_reps_ok) begin
          st = StRepeat;
        end else begin
          st = StOk;
        end
        if (st == StOk) begin
          if (sh_v6 ? sh_cfg.fwd_v6 : sh_cfg.fwd_v4) v.forward = 1'b1;
          else st = StFamily;
        end
      end
      v.status = st;
      verdict_q = {verdict_q, v};
      clear_checks();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_checks();
      sh_v6  = 1'b0;
      sh_cfg = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CfgFilterEn: sh_cfg.filter_en = cfg_data[0];
          CfgExpMac:   sh_cfg.exp_mac   = cfg_data;
          CfgFwdV4:    sh_cfg.fwd_v4    = cfg_data[0];
          CfgFwdV6:    sh_cfg.fwd_v6    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_verdict(in_item);
    end
  end

  task automatic flag_mismatch(input string field, input logic [MacW-1:0] want,
                               input logic [MacW-1:0] got);
    err_cnt++;
    if (err_cnt <= PrintLimit) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // compare each accepted verdict transaction with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdict_cnt++;
      if (out_item.forward) fwd_cnt++;
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= PrintLimit) begin
          $display("%0t: unexpected verdict, expected none, actual %0h", $time, out_item);
        end
      end else begin
        want = verdict_q.pop_front();
        if (out_item.forward !== want.forward)
          flag_mismatch("forward", want.forward, out_item.forward);
        if (out_item.status !== want.status)
          flag_mismatch("status", want.status, out_item.status);
        if (out_item.wake_mac !== want.wake_mac)
          flag_mismatch("wake_mac", want.wake_mac, out_item.wake_mac);
        if (out_item.family_ipv6 !== want.family_ipv6)
          flag_mismatch("family_ipv6", want.family_ipv6, out_item.family_ipv6);
      end
    end
  end

  // receiver back-pressure in bursts, with long clear stretches
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20))
          @(posedge clk);
        if (!quiet) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("cycle limit of %0d reached, %0d verdicts outstanding", CycleLimit,
             verdict_q.size());
    $display("tb_magic_packet_checker_core failed");
    $finish;
  end

  function automatic logic [MacW-1:0] rnd_mac();
    return {16'($urandom), $urandom};
  endfunction

  function automatic byte_q_t magic_bytes(input logic [MacW-1:0] mac, input int unsigned tail);
    byte_q_t b;
    repeat (PrefixLen) b = {b, FillByte};
    repeat (RepeatCount) begin
      for (int k = MacBytes; k > 0; k--) b = {b, mac[8*k-1 -: 8]};
    end
    repeat (tail) b = {b, 8'($urandom)};
    return b;
  endfunction

  function automatic byte_q_t flip_byte(input byte_q_t b, input int unsigned lo,
                                        input int unsigned hi);
    int unsigned idx;
    idx = $urandom_range(lo, hi);
    b[idx] = b[idx] ^ 8'($urandom_range(1, 255));
    return b;
  endfunction

  function automatic byte_q_t cut_to(input byte_q_t b, input int unsigned len);
    while (b.size() > len) void'(b.pop_back());
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] d, input bit f, input bit l, input bit v6);
    if (!quiet && in_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: d, first_byte: f, last_byte: l, is_ipv6: v6};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // family bit only counts on the opening byte, the rest carry noise there
  task automatic send_payload(input byte_q_t pl, input bit v6, input bit mark_first,
                              input bit close);
    in_gaps = ($urandom_range(0, 3) != 0);
    foreach (pl[i]) begin
      send_byte(pl[i], mark_first && i == 0, close && i == pl.size() - 1,
                (i == 0) ? v6 : 1'($urandom_range(0, 1)));
    end
    payload_cnt++;
    if (close) closed_cnt++;
  endtask

  // registers only change once every verdict is out and the pipe has drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input bit filt, input logic [MacW-1:0] mac, input bit v4,
                            input bit v6);
    logic [MacW-1:0] junk;
    cur_cfg = '{filter_en: filt, exp_mac: mac, fwd_v4: v4, fwd_v6: v6};
    phase_cnt++;
    junk = rnd_mac();
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgFilterEn;
    cfg_data <= {junk[MacW-1:1], filt};
    @(posedge clk);
    cfg_idx  <= CfgExpMac;
    cfg_data <= mac;
    @(posedge clk);
    cfg_idx  <= CfgFwdV4;
    cfg_data <= {junk[MacW-2:0], v4};
    @(posedge clk);
    cfg_idx  <= CfgFwdV6;
    cfg_data <= {~junk[MacW-1:1], v6};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_after_reset();
    // registers still at reset: no family forwards
    send_payload(magic_bytes(48'h0123_4567_89ab, 0), 1'b0, 1'b1, 1'b1);
    send_payload('{FillByte}, 1'b1, 1'b1, 1'b1);
    send_payload(magic_bytes(rnd_mac(), 3), 1'b1, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_verdict_codes();
    logic [MacW-1:0] mac;
    byte_q_t         m;
    mac = rnd_mac();
    m   = magic_bytes(mac, 0);
    set_config(1'b0, '0, 1'b1, 1'b1);
    send_payload(m, 1'b0, 1'b1, 1'b1);
    send_payload(magic_bytes('0, 0), 1'b1, 1'b1, 1'b1);
    send_payload(magic_bytes('1, 0), 1'b0, 1'b1, 1'b1);
    send_payload(cut_to(m, FullLen - 1), 1'b1, 1'b1, 1'b1);
    send_payload(magic_bytes(mac, 20), 1'b0, 1'b1, 1'b1);
    send_payload(flip_byte(m, 0, 0), 1'b0, 1'b1, 1'b1);
    send_payload(flip_byte(m, PrefixLen - 1, PrefixLen - 1), 1'b1, 1'b1, 1'b1);
    send_payload(flip_byte(m, FullLen - 1, FullLen - 1), 1'b0, 1'b1, 1'b1);
    send_payload(flip_byte(m, PrefixLen + MacBytes, PrefixLen + MacBytes), 1'b1, 1'b1, 1'b1);
    send_payload(flip_byte(m, PrefixLen, PrefixLen + MacBytes - 1), 1'b0, 1'b1, 1'b1);
    // prefix error wins over a repetition error
    send_payload(flip_byte(flip_byte(m, 0, PrefixLen - 1), PrefixLen + MacBytes, FullLen - 1),
                 1'b1, 1'b1, 1'b1);
    send_payload(cut_to(magic_bytes('0, 0), FullLen), 1'b0, 1'b1, 1'b1);
    // abandoned payload, restarted by a first mark
    send_payload(cut_to(m, 50), 1'b1, 1'b1, 1'b0);
    send_payload(m, 1'b0, 1'b1, 1'b1);
    send_payload(m, 1'b1, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_mac_filter();
    logic [MacW-1:0] mac;
    mac = rnd_mac();
    set_config(1'b1, mac, 1'b1, 1'b1);
    send_payload(magic_bytes(mac, 0), 1'b0, 1'b1, 1'b1);
    send_payload(magic_bytes(mac ^ 48'h1, 0), 1'b1, 1'b1, 1'b1);
    send_payload(flip_byte(magic_bytes(mac, 0), PrefixLen + MacBytes, FullLen - 1),
                 1'b0, 1'b1, 1'b1);
    send_payload(flip_byte(magic_bytes(mac, 0), 0, PrefixLen - 1), 1'b1, 1'b1, 1'b1);
    settle();
    set_config(1'b1, '0, 1'b1, 1'b0);
    send_payload(magic_bytes('0, 0), 1'b0, 1'b1, 1'b1);
    send_payload(magic_bytes('0, 0), 1'b1, 1'b1, 1'b1);
    settle();
    set_config(1'b1, '1, 1'b0, 1'b1);
    send_payload(magic_bytes('1, 0), 1'b1, 1'b1, 1'b1);
    send_payload(magic_bytes('1, 0), 1'b0, 1'b1, 1'b1);
    settle();
  endtask

  task automatic random_payload(input bit allow_open);
    byte_q_t         pl;
    logic [MacW-1:0] mac;
    int unsigned     pick;
    bit              close;
    close = 1'b1;
    mac   = (cur_cfg.filter_en && $urandom_range(0, 3) != 0) ? cur_cfg.exp_mac : rnd_mac();
    pick  = $urandom_range(0, 99);
    pl    = magic_bytes(mac, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0);
    if (pick >= 55 && pick < 70) begin
      pl = flip_byte(pl, 0, FullLen - 1);
    end else if (pick >= 70 && pick < 80) begin
      pl = cut_to(pl, $urandom_range(1, FullLen - 1));
    end else if (pick >= 80 && pick < 90) begin
      pl.delete();
      repeat ($urandom_range(1, 120)) pl = {pl, 8'($urandom)};
    end else if (pick >= 90 && allow_open) begin
      pl    = cut_to(pl, $urandom_range(1, FullLen + 10));
      close = 1'b0;
    end
    send_payload(pl, 1'($urandom_range(0, 1)), open_payload || $urandom_range(0, 7) != 0,
                 close);
    open_payload = !close;
  endtask

  task automatic test_random_traffic();
    int unsigned     phase_left;
    logic [MacW-1:0] mac;
    phase_left = 0;
    while (bytes_sent < 1800) begin
      if (phase_left == 0 && !open_payload) begin
        settle();
        case ($urandom_range(0, 3))
          0:       mac = '0;
          1:       mac = '1;
          default: mac = rnd_mac();
        endcase
        set_config($urandom_range(0, 2) == 0, mac, $urandom_range(0, 3) != 0,
                   $urandom_range(0, 3) != 0);
        phase_left = $urandom_range(4, 10);
      end
      random_payload(1'b1);
      if (!open_payload && phase_left != 0) phase_left--;
    end
    // closing stretch at full rate on both sides
    quiet = 1'b1;
    repeat (8) random_payload(1'b0);
    settle();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgFilterEn;
    cfg_data     = '0;
    quiet        = 1'b0;
    in_gaps      = 1'b0;
    open_payload = 1'b0;
    cur_cfg      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_verdict_codes();
    test_mac_filter();
    test_random_traffic();
    $display("%0d payloads (%0d closed) over %0d bytes in %0d register settings", payload_cnt,
             closed_cnt, bytes_sent, phase_cnt);
    $display("%0d verdicts compared, %0d forwarded, %0d errors", verdict_cnt, fwd_cnt, err_cnt);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("tb_magic_packet_checker_core passed");
    end else begin
      $display("tb_magic_packet_checker_core failed");
    end
    $finish;
  end

endmodule
